FILE: rtl/eifg_pkg.sv
// Shared types, constants and the CRC step function for the ESL IR frame generator.
package eifg_pkg;

	typedef enum logic [1:0] {
		FUNC_PAGE  = 2'd0,
		FUNC_DEBUG = 2'd1,
		FUNC_PING  = 2'd2,
		FUNC_RSV   = 2'd3
	} func_t;

	localparam logic [15:0] CRC_POLY    = 16'h8408;
	localparam logic [15:0] CRC_INIT    = 16'h8408;
	localparam logic [7:0]  CMD_PAGE    = 8'h06;
	localparam logic [7:0]  CMD_PING    = 8'h17;
	localparam logic [7:0]  DEBUG_HEAD  = 8'hF1;
	localparam logic [7:0]  DEBUG_TAIL  = 8'h0A;
	localparam logic [7:0]  FOREVER_BIT = 8'h80;
	localparam logic [7:0]  PAGE_FLAG   = 8'h01;
	localparam logic [7:0]  PING_HEAD   = 8'h01;
	localparam logic [7:0]  FILL_BYTE   = 8'h01;

	// header (6) plus fixed body (5)
	localparam int HDR_BODY_LEN      = 11;
	// header (6) plus ping body (4), fill bytes follow
	localparam int PING_HDR_BODY_LEN = 10;
	localparam int BODY_LEN          = 5;
	localparam int Q_DEPTH           = 2;

	typedef struct packed {
		logic                     ping;
		logic [31:0]              id;
		logic [7:0]               cmd;
		logic [BODY_LEN-1:0][7:0] body;
	} desc_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

FILE: rtl/eifg_front.sv
// Front end: accepts frame requests, drops reserved kinds, builds a frame descriptor.
module eifg_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [55:0]          s_tdata,
	input  logic                 q_full,
	output logic                 q_push,
	output eifg_pkg::desc_t      q_desc
);

	eifg_pkg::func_t func;
	logic [2:0]      page_number;
	logic            show_forever;
	logic [15:0]     show_duration;
	logic [31:0]     tag_id;
	logic [7:0]      page_byte;
	logic [15:0]     dur;
	logic            busy_q;

	assign func          = eifg_pkg::func_t'(s_tdata[1:0]);
	assign page_number   = s_tdata[4:2];
	assign show_forever  = s_tdata[5];
	assign show_duration = s_tdata[21:6];
	assign tag_id        = s_tdata[53:22];

	// hold off input while the busy register still holds its reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign s_tready = !q_full && !busy_q;
	assign q_push   = s_tvalid && s_tready && (func != eifg_pkg::FUNC_RSV);

	assign page_byte = {2'b00, page_number, 3'b000} | eifg_pkg::PAGE_FLAG
		| (show_forever ? eifg_pkg::FOREVER_BIT : 8'h00);
	assign dur = show_forever ? 16'h0000 : show_duration;

	always_comb begin
		q_desc = '0;
		unique case (func)
			eifg_pkg::FUNC_PAGE: begin
				q_desc.cmd     = eifg_pkg::CMD_PAGE;
				q_desc.body[0] = page_byte;
				q_desc.body[3] = dur[15:8];
				q_desc.body[4] = dur[7:0];
			end
			eifg_pkg::FUNC_DEBUG: begin
				q_desc.cmd     = eifg_pkg::CMD_PAGE;
				q_desc.body[0] = eifg_pkg::DEBUG_HEAD;
				q_desc.body[4] = eifg_pkg::DEBUG_TAIL;
			end
			eifg_pkg::FUNC_PING: begin
				q_desc.ping    = 1'b1;
				q_desc.id      = tag_id;
				q_desc.cmd     = eifg_pkg::CMD_PING;
				q_desc.body[0] = eifg_pkg::PING_HEAD;
			end
			default: begin
				q_desc = '0;
			end
		endcase
	end

endmodule

FILE: rtl/eifg_queue.sv
// Two-entry descriptor queue between the front end and the byte sequencer.
module eifg_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  eifg_pkg::desc_t push_desc,
	output logic            full,
	input  logic            pop,
	output logic            nonempty,
	output eifg_pkg::desc_t head
);

	eifg_pkg::desc_t mem_q [eifg_pkg::Q_DEPTH];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	assign full     = (count_q == 2'(eifg_pkg::Q_DEPTH));
	assign nonempty = (count_q != 2'd0);
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/eifg_back.sv
// Back end: walks one descriptor byte by byte, runs the CRC, drives the output register.
module eifg_back #(
	parameter int PING_FILL_COUNT = 22
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [7:0]      protocol_byte,
	input  logic            q_nonempty,
	input  eifg_pkg::desc_t q_head,
	output logic            q_pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [7:0]      m_tdata,
	output logic            m_tlast
);

	localparam int FRAME_LEN_MAX = eifg_pkg::PING_HDR_BODY_LEN + PING_FILL_COUNT + 2;
	localparam int IDX_W         = $clog2(FRAME_LEN_MAX);

	logic [IDX_W-1:0] idx_q;
	logic [15:0]      crc_q;
	logic [IDX_W-1:0] data_len;
	logic [IDX_W-1:0] body_end;
	logic [IDX_W-1:0] body_off;
	logic [2:0]       body_sel;
	logic [1:0]       id_sel;
	logic [7:0]       byte_val;
	logic             in_data;
	logic             is_last;
	logic             advance;
	logic [7:0]       out_data_q;
	logic             out_last_q;
	logic             out_valid_q;

	assign data_len = q_head.ping ? IDX_W'(eifg_pkg::PING_HDR_BODY_LEN + PING_FILL_COUNT)
		: IDX_W'(eifg_pkg::HDR_BODY_LEN);
	assign body_end = q_head.ping ? IDX_W'(eifg_pkg::PING_HDR_BODY_LEN)
		: IDX_W'(eifg_pkg::HDR_BODY_LEN);
	assign in_data  = (idx_q < data_len);
	assign is_last  = (idx_q == data_len + IDX_W'(1));
	assign body_off = idx_q - IDX_W'(6);
	assign body_sel = body_off[2:0];
	assign id_sel   = 2'(IDX_W'(4) - idx_q);

	always_comb begin
		if (idx_q == IDX_W'(0)) begin
			byte_val = protocol_byte;
		end else if (idx_q <= IDX_W'(4)) begin
			byte_val = q_head.id[8*id_sel +: 8];
		end else if (idx_q == IDX_W'(5)) begin
			byte_val = q_head.cmd;
		end else if (idx_q < body_end) begin
			byte_val = q_head.body[body_sel];
		end else if (in_data) begin
			byte_val = eifg_pkg::FILL_BYTE;
		end else if (idx_q == data_len) begin
			byte_val = crc_q[7:0];
		end else begin
			byte_val = crc_q[15:8];
		end
	end

	assign advance = q_nonempty && (!out_valid_q || m_tready);
	assign q_pop   = advance && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			crc_q       <= eifg_pkg::CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				if (is_last) begin
					idx_q <= '0;
					crc_q <= eifg_pkg::CRC_INIT;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
					if (in_data) begin
						crc_q <= eifg_pkg::crc_byte(crc_q, byte_val);
					end
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= byte_val;
			out_last_q <= is_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

FILE: rtl/esl_ir_frame_generator_unit.sv
// Top level of the ESL IR frame generator: front end, descriptor queue, byte sequencer.
// Each request on the slave stream becomes one frame on the master stream, one byte per
// transfer with tlast on the final CRC byte: 13 bytes for page and debug frames and
// 12 + PING_FILL_COUNT bytes for ping frames (34 at the default of 22). The byte
// sequencer emits one byte per cycle, stalling while the master stream holds m_tready low;
// a two-entry queue lets new requests be taken while a frame is still going out.
// Requests with the reserved kind code are taken and produce no frame. The protocol
// byte register resets to 133 and should be written only while no frame is in flight.
module esl_ir_frame_generator_unit #(
	parameter int PING_FILL_COUNT = 22
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// func[1:0], page_number[4:2], show_forever[5], show_duration[21:6], tag_id[53:22]
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// frame_byte[7:0]
	output logic [7:0]  m_tdata,
	output logic        m_tlast
);

	logic [7:0]      protocol_q;
	logic            q_full;
	logic            q_push;
	logic            q_pop;
	logic            q_nonempty;
	eifg_pkg::desc_t q_desc;
	eifg_pkg::desc_t q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			protocol_q <= 8'd133;
		end else if (cfg_valid && cfg_ready) begin
			protocol_q <= cfg_data;
		end
	end

	eifg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_desc   (q_desc)
	);

	eifg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (q_desc),
		.full      (q_full),
		.pop       (q_pop),
		.nonempty  (q_nonempty),
		.head      (q_head)
	);

	eifg_back #(
		.PING_FILL_COUNT (PING_FILL_COUNT)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.protocol_byte (protocol_q),
		.q_nonempty    (q_nonempty),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast)
	);

endmodule

FILE: tb/esl_ir_frame_generator_unit_test.sv
// Testbench for the ESL IR frame generator: directed and random frame requests, bytes checked against a local frame builder.
module esl_ir_frame_generator_unit_test;

	localparam logic [7:0] PROTO_RESET   = 8'd133;
	localparam int         FILL_COUNT    = 22;
	localparam int         SETTLE_CYCLES = 64;
	localparam int         WATCHDOG_MAX  = 2000;

	// field order matches s_tdata, lowest bits last
	typedef struct packed {
		logic [31:0]     tag_id;
		logic [15:0]     show_duration;
		logic            show_forever;
		logic [2:0]      page_number;
		eifg_pkg::func_t func;
	} frame_req_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} frame_beat_t;

	typedef struct packed {
		frame_req_t req;
		logic       no_frame;
	} dir_row_t;

	localparam int DIR_ROWS = 18;
	localparam dir_row_t DIRECTED [0:DIR_ROWS-1] = '{
		'{'{32'h0000_0000, 16'h0000, 1'b0, 3'd0, eifg_pkg::FUNC_PAGE}, 1'b0},
		'{'{32'h0000_0000, 16'hFFFF, 1'b0, 3'd7, eifg_pkg::FUNC_PAGE}, 1'b0},
		'{'{32'h0000_0000, 16'hFFFF, 1'b1, 3'd7, eifg_pkg::FUNC_PAGE}, 1'b0},
		'{'{32'h0000_0000, 16'h1234, 1'b0, 3'd5, eifg_pkg::FUNC_PAGE}, 1'b0},
		'{'{32'h0000_0000, 16'h0000, 1'b1, 3'd2, eifg_pkg::FUNC_PAGE}, 1'b0},
		'{'{32'h0000_0000, 16'h8000, 1'b0, 3'd0, eifg_pkg::FUNC_PAGE}, 1'b0},
		'{'{32'h0000_0000, 16'h00FF, 1'b0, 3'd1, eifg_pkg::FUNC_PAGE}, 1'b0},
		'{'{32'hFFFF_FFFF, 16'hFFFF, 1'b1, 3'd7, eifg_pkg::FUNC_DEBUG}, 1'b0},
		'{'{32'h0000_0000, 16'h0000, 1'b0, 3'd0, eifg_pkg::FUNC_DEBUG}, 1'b0},
		'{'{32'h0000_0000, 16'h0000, 1'b0, 3'd0, eifg_pkg::FUNC_PING}, 1'b0},
		'{'{32'hFFFF_FFFF, 16'h0000, 1'b0, 3'd0, eifg_pkg::FUNC_PING}, 1'b0},
		'{'{32'h1234_5678, 16'h0000, 1'b0, 3'd0, eifg_pkg::FUNC_PING}, 1'b0},
		'{'{32'h8000_0001, 16'h0000, 1'b0, 3'd0, eifg_pkg::FUNC_PING}, 1'b0},
		'{'{32'h0000_0000, 16'h0000, 1'b0, 3'd0, eifg_pkg::FUNC_RSV}, 1'b1},
		'{'{32'hFFFF_FFFF, 16'hFFFF, 1'b1, 3'd7, eifg_pkg::FUNC_RSV}, 1'b1},
		'{'{32'h0000_0000, 16'h0102, 1'b0, 3'd3, eifg_pkg::FUNC_PAGE}, 1'b0},
		'{'{32'hA5A5_5A5A, 16'hFFFF, 1'b1, 3'd7, eifg_pkg::FUNC_PING}, 1'b0},
		'{'{32'hFFFF_FFFF, 16'hBEEF, 1'b0, 3'd4, eifg_pkg::FUNC_PAGE}, 1'b0}
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	frame_beat_t frame_bytes_due [$];
	logic [7:0]  proto_shadow;
	int          errors = 0;
	int          quiet_cycles = 0;
	bit          calm = 1'b0;

	esl_ir_frame_generator_unit #(
		.PING_FILL_COUNT(FILL_COUNT)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] d);
		logic [15:0] r;
		logic        fb;
		r = acc;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ d[i];
			r = r >> 1;
			if (fb) begin
				r = r ^ eifg_pkg::CRC_POLY;
			end
		end
		return r;
	endfunction

	task automatic build_frame(input frame_req_t rq);
		logic [7:0]  frm [$];
		logic [15:0] crc;
		if (rq.func == eifg_pkg::FUNC_RSV) begin
			return;
		end
		frm.push_back(proto_shadow);
		if (rq.func == eifg_pkg::FUNC_PING) begin
			frm.push_back(rq.tag_id[31:24]);
			frm.push_back(rq.tag_id[23:16]);
			frm.push_back(rq.tag_id[15:8]);
			frm.push_back(rq.tag_id[7:0]);
			frm.push_back(eifg_pkg::CMD_PING);
			frm.push_back(eifg_pkg::PING_HEAD);
			repeat (3) frm.push_back(8'h00);
			repeat (FILL_COUNT) frm.push_back(eifg_pkg::FILL_BYTE);
		end else begin
			repeat (4) frm.push_back(8'h00);
			frm.push_back(eifg_pkg::CMD_PAGE);
			if (rq.func == eifg_pkg::FUNC_PAGE) begin
				frm.push_back(({5'd0, rq.page_number} << 3) | eifg_pkg::PAGE_FLAG |
					(rq.show_forever ? eifg_pkg::FOREVER_BIT : 8'h00));
				frm.push_back(8'h00);
				frm.push_back(8'h00);
				frm.push_back(rq.show_forever ? 8'h00 : rq.show_duration[15:8]);
				frm.push_back(rq.show_forever ? 8'h00 : rq.show_duration[7:0]);
			end else begin
				frm.push_back(eifg_pkg::DEBUG_HEAD);
				repeat (3) frm.push_back(8'h00);
				frm.push_back(eifg_pkg::DEBUG_TAIL);
			end
		end
		crc = eifg_pkg::CRC_INIT;
		foreach (frm[i]) begin
			crc = crc_step(crc, frm[i]);
		end
		frm.push_back(crc[7:0]);
		frm.push_back(crc[15:8]);
		foreach (frm[i]) begin
			frame_bytes_due.push_back('{frm[i], (i == frm.size() - 1)});
		end
	endtask

	function automatic frame_req_t random_request();
		frame_req_t  r;
		logic [31:0] w;
		w = $urandom;
		r.page_number  = w[2:0];
		r.show_forever = w[3];
		if ($urandom_range(0, 9) == 0) begin
			r.func = eifg_pkg::FUNC_RSV;
		end else begin
			case ($urandom_range(0, 2))
				0: r.func = eifg_pkg::FUNC_PAGE;
				1: r.func = eifg_pkg::FUNC_DEBUG;
				default: r.func = eifg_pkg::FUNC_PING;
			endcase
		end
		case ($urandom_range(0, 5))
			0: r.show_duration = 16'h0000;
			1: r.show_duration = 16'hFFFF;
			default: begin
				w = $urandom;
				r.show_duration = w[15:0];
			end
		endcase
		case ($urandom_range(0, 5))
			0: r.tag_id = 32'h0000_0000;
			1: r.tag_id = 32'hFFFF_FFFF;
			default: r.tag_id = $urandom;
		endcase
		return r;
	endfunction

	task automatic send_request(input frame_req_t rq, input bit no_frame);
		logic [63:0] junk;
		int          gap;
		junk = {$urandom, $urandom};
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {junk[1:0], rq};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (!no_frame) begin
			build_frame(rq);
		end
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			@(negedge clk);
			s_tvalid <= 1'b0;
			s_tdata  <= junk[63:8];
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic write_protocol(input logic [7:0] value);
		logic [31:0] junk;
		junk = $urandom;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		proto_shadow = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
		cfg_data  <= junk[7:0];
	endtask

	task automatic settle_out();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (frame_bytes_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(input int frames);
		frame_req_t rq;
		int         made;
		made = 0;
		while (made < frames) begin
			rq = random_request();
			send_request(rq, 1'b0);
			if (rq.func != eifg_pkg::FUNC_RSV) begin
				made++;
			end
		end
	endtask

	initial begin
		logic [31:0] rnd;
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = 8'h00;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		proto_shadow = PROTO_RESET;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED[i]) begin
			send_request(DIRECTED[i].req, DIRECTED[i].no_frame);
		end

		settle_out();
		write_protocol(8'hFF);
		run_random(50);

		settle_out();
		write_protocol(8'h00);
		run_random(50);

		settle_out();
		rnd = $urandom;
		write_protocol(rnd[7:0]);
		run_random(50);

		settle_out();
		rnd = $urandom;
		write_protocol(rnd[7:0]);
		calm = 1'b1;
		run_random(60);

		@(negedge clk);
		s_tvalid <= 1'b0;
		settle_out();

		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		int hold;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(1, 10);
				m_tready <= 1'b0;
				repeat (hold - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : frame_check
		frame_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (frame_bytes_due.size() == 0) begin
				$error("frame_byte unexpected transfer, actual %0h", m_tdata);
				errors++;
			end else begin
				want = frame_bytes_due.pop_front();
				if (m_tdata !== want.frame_byte) begin
					$error("frame_byte expected %0h actual %0h", want.frame_byte, m_tdata);
					errors++;
				end
				if (m_tlast !== want.last_byte) begin
					$error("last_byte expected %0b actual %0b", want.last_byte, m_tlast);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_MAX) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
